>>> hdl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal text block.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define S2DA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define S2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define S2DA_ASSERT_IMPL(lbl, ante, cons, msg)
`define S2DA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/s2da_pkg.sv
// Package with types and constants for the signed integer to decimal text block.
`default_nettype none
package s2da_pkg;

  localparam int unsigned BIN_W  = 32;
  localparam int unsigned DIGITS = 10;
  localparam int unsigned BCD_W  = 4 * DIGITS;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CHAR_W = 6;

  localparam logic [CNT_W-1:0]  LAST_STEP   = CNT_W'(BIN_W - 1);
  localparam logic [CNT_W-1:0]  TOP_DIGIT   = CNT_W'(DIGITS - 1);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Operations of the shared shift unit.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DABBLE,
    OP_SHIFT_DIGIT
  } bcd_op_t;

  // Command from the sequencer to the shift unit.
  typedef struct packed {
    bcd_op_t            op;
    logic [BIN_W-1:0]   mag;
  } bcd_cmd_t;

endpackage
`default_nettype wire

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text block.
// Each accepted value is sent out as its decimal text, one ASCII character per
// request, most significant first, with a leading '-' for negative values and the
// final character flagged by out_last. One item at a time: in_ready is high only
// while the sequencer is idle. After acceptance the shared shift unit runs the
// shift-and-add-3 conversion over all 32 magnitude bits, then drops the leading
// zero digits one at a time, and then the text goes out character by character
// (1 to 11), held whenever the result side holds a character back. Leading zeros
// and digits always fill the ten BCD positions. The output register lets the
// next value be accepted while the final character waits.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"
module signed_int_to_decimal_ascii
  import s2da_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [31:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_last
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               sign_pending_r, sign_pending_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_free;
  logic [3:0]         top_digit;
  bcd_cmd_t           cmd;

  s2da_bcd_unit u_bcd (
    .clk       (clk),
    .cmd       (cmd),
    .top_digit (top_digit)
  );

  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state, unit commands and output register loads.
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    neg_nxt          = neg_r;
    sign_pending_nxt = sign_pending_r;
    cmd.op           = OP_HOLD;
    cmd.mag          = in_value[31] ? (~in_value + 32'd1) : in_value;
    out_char_nxt     = out_char_r;
    out_last_nxt     = out_last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    in_ready         = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          neg_nxt   = in_value[31];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.op  = OP_DABBLE;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = TOP_DIGIT;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits, but always keep the units digit.
        if (top_digit == 4'd0 && cnt_r != '0) begin
          cmd.op  = OP_SHIFT_DIGIT;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          sign_pending_nxt = neg_r;
          state_nxt        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pending_r) begin
            out_char_nxt     = ASCII_MINUS;
            out_last_nxt     = 1'b0;
            sign_pending_nxt = 1'b0;
          end else begin
            cmd.op       = OP_SHIFT_DIGIT;
            out_char_nxt = ASCII_ZERO + {2'b00, top_digit};
            out_last_nxt = (cnt_r == '0);
            if (cnt_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    neg_r          <= neg_nxt;
    sign_pending_r <= sign_pending_nxt;
    out_char_r     <= out_char_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // A pending character is always a minus sign or a decimal digit.
  `S2DA_ASSERT_IMPL(a_char_range, out_valid_r,
    (out_char_r == ASCII_MINUS) || (out_char_r >= ASCII_ZERO && out_char_r <= ASCII_NINE),
    "character outside the minus sign and digit codes")
  // The minus sign never closes a number's text.
  `S2DA_ASSERT_IMPL(a_minus_not_last, out_valid_r && (out_char_r == ASCII_MINUS),
    !out_last_r, "minus sign flagged as last character")
  // The digit counter stays within the ten BCD digits while digits are handled.
  `S2DA_ASSERT_IMPL(a_digit_count, (state_r == ST_SKIP) || (state_r == ST_EMIT),
    cnt_r <= TOP_DIGIT, "digit counter beyond the top BCD digit")
  // An accepted value always starts a fresh conversion.
  `S2DA_ASSERT_NEXT(a_start_conv, in_valid && in_ready,
    (state_r == ST_CONV) && (cnt_r == '0), "accepted value did not start conversion")

endmodule
`default_nettype wire

>>> hdl/s2da_bcd_unit.sv
// Shared shift unit: binary to BCD by shift-and-add-3, then digit-wise shift-out.
`default_nettype none
module s2da_bcd_unit
  import s2da_pkg::*;
(
  input  wire logic       clk,
  input  wire bcd_cmd_t   cmd,
  output logic [3:0]      top_digit
);

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  // Add 3 to every BCD digit that is 5 or more, ahead of the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Select the operation requested by the sequencer.
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        bin_nxt = cmd.mag;
        bcd_nxt = '0;
      end
      OP_DABBLE: begin
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
      end
      OP_SHIFT_DIGIT: begin
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
      end
      default: begin
      end
    endcase
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule
`default_nettype wire

>>> bench/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed integer to decimal ASCII text block.
module signed_int_to_decimal_ascii_tb;
  import s2da_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_ITEMS   = 310;
  localparam int CALM_ITEMS     = 40;
  localparam int DRAIN_CYCLES   = 60;
  localparam int DIRECTED_COUNT = 22;

  // One expected character of a number's text.
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // One row of the directed table; an empty text means the predictor decides.
  typedef struct {
    logic [31:0] value;
    string       text;
  } directed_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  text_char_t    decimal_char_q[$];
  string         typed_text_q[$];
  directed_row_t directed_rows[DIRECTED_COUNT];
  int            mismatch_count;
  int            quiet_cycles;
  bit            calm;
  bit            sender_gaps;

  signed_int_to_decimal_ascii DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Appends the decimal text of a 32-bit two's complement value to the expected store.
  function automatic void render_decimal(input logic [31:0] raw);
    logic [31:0] mag;
    logic        neg;
    logic [3:0]  digit_q[$];
    text_char_t  ch;
    neg = raw[31];
    mag = neg ? (~raw + 32'd1) : raw;
    do begin
      digit_q.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (neg) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      decimal_char_q.push_back(ch);
    end
    foreach (digit_q[i]) begin
      ch.code = ASCII_ZERO + CHAR_W'(digit_q[i]);
      ch.last = (i == digit_q.size() - 1);
      decimal_char_q.push_back(ch);
    end
  endfunction

  // Appends a typed-in text to the expected store, last flag on its final character.
  function automatic void push_typed_text(input string text);
    text_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.code = CHAR_W'(text[i]);
      ch.last = (i == text.len() - 1);
      decimal_char_q.push_back(ch);
    end
  endfunction

  // Draws a random value, weighted toward digit-count boundaries and inner zeros.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p;
    int          kind;
    kind = $urandom_range(0, 9);
    p = 32'd1;
    case (kind)
      0, 1, 2, 3: begin
        v = $urandom;
      end
      4: begin
        v = $urandom_range(0, 20);
      end
      5: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      6: begin
        v = 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
      end
      7: begin
        v = 32'd0;
        repeat ($urandom_range(2, 9)) begin
          v = v * 32'd10 + (($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(1, 9)));
        end
      end
      default: begin
        v = $urandom_range(0, 99999);
      end
    endcase
    if (kind != 0 && kind != 1 && kind != 2 && kind != 3 && $urandom_range(0, 1) == 1) begin
      v = ~v + 32'd1;
    end
    return v;
  endfunction

  // Holds one request on the input channel until it is taken, with an optional gap first.
  task automatic send_value(input logic [31:0] v, input string text);
    if (sender_gaps && !calm && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    typed_text_q.push_back(text);
    in_value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected character has come out.
  task automatic drain_results();
    in_valid = 1'b0;
    while (decimal_char_q.size() != 0) @(negedge clk);
  endtask

  // Request monitor: predicts on input requests and checks output requests.
  always @(posedge clk) begin
    text_char_t exp_ch;
    string      text;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && in_ready) begin
        text = typed_text_q.pop_front();
        if (text == "") begin
          render_decimal(in_value);
        end else begin
          push_typed_text(text);
        end
      end
      if (out_valid && out_ready) begin
        if (decimal_char_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last %0b",
                                    out_character, out_last));
        end else begin
          exp_ch = decimal_char_q.pop_front();
          if (out_character !== exp_ch.code) begin
            report_mismatch($sformatf("character %0d, expected %0d",
                                      out_character, exp_ch.code));
          end
          if (out_last !== exp_ch.last) begin
            report_mismatch($sformatf("last %0b, expected %0b on character %0d",
                                      out_last, exp_ch.last, exp_ch.code));
          end
        end
      end
    end
  end

  // Result side: stalls in random bursts, no new burst once the run turns calm.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles without any request.
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    sender_gaps = 1'b1;

    // Extremes, zero, single digits, inner zeros and digit-count boundaries.
    directed_rows = '{
      '{32'd0,                "0"},
      '{32'd1,                "1"},
      '{32'hFFFF_FFFF,        "-1"},
      '{32'd9,                "9"},
      '{32'hFFFF_FFF7,        "-9"},
      '{32'h7FFF_FFFF,        "2147483647"},
      '{32'h8000_0000,        "-2147483648"},
      '{32'h8000_0001,        ""},
      '{32'd10,               ""},
      '{32'hFFFF_FFF6,        ""},
      '{32'd99,               ""},
      '{32'd100,              ""},
      '{32'd101,              ""},
      '{32'd999_999_999,      ""},
      '{32'd1_000_000_000,    ""},
      '{32'd1_000_000_007,    ""},
      '{32'd1_010_101_010,    ""},
      '{-32'sd1_000_000_001,  ""},
      '{32'h5555_5555,        ""},
      '{32'hAAAA_AAAA,        ""},
      '{32'd305_419_896,      ""},
      '{-32'sd100_000,        ""}
    };

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value, directed_rows[i].text);
    end
    drain_results();

    // Random values, with sender gaps switched on and off in stretches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      send_value(pick_value(), "");
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
